>>> rtl/pf_pkg.sv
// ----------------------------------------------------------------------------
// Playfair package
// Shared widths, letter codes, key square types and lookup helpers.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int KEY_ROWS = 5;
    localparam int KEY_COLS = 5;
    localparam int CODE_W   = 5;
    localparam int POS_W    = 3;
    localparam int ROW_W    = KEY_COLS * CODE_W;
    localparam int CFG_IDX_W = 3;
    localparam int LETTER_W = 7;
    localparam int BYTE_W   = 8;

    // Letter codes, 0 = A .. 25 = Z
    localparam logic [CODE_W-1:0] CODE_X = 5'd23;
    localparam logic [CODE_W-1:0] CODE_I = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J = 5'd9;

    localparam logic [BYTE_W-1:0] ASCII_UC_A = 8'd65;
    localparam logic [BYTE_W-1:0] ASCII_UC_Z = 8'd90;
    localparam logic [BYTE_W-1:0] ASCII_LC_A = 8'd97;
    localparam logic [BYTE_W-1:0] ASCII_LC_Z = 8'd122;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [LETTER_W-1:0] LETTER_A = 7'd65;

    typedef logic [ROW_W-1:0]    t_key_row;
    typedef t_key_row [KEY_ROWS-1:0] t_key_sq;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pos;

    typedef struct packed {
        logic                done;
        logic                valid;
        logic [LETTER_W-1:0] letter;
    } t_result;

    // Default square, row 4 first
    localparam t_key_sq KEY_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                     25'd10755269, 25'd4294688};

    function automatic logic [CODE_W-1:0] f_cell(t_key_sq key, logic [POS_W-1:0] row,
                                                 logic [POS_W-1:0] col);
        t_key_row r;
        r = key[row];
        return r[col*CODE_W +: CODE_W];
    endfunction

    function automatic logic [POS_W-1:0] f_wrap_inc(logic [POS_W-1:0] x);
        return (x == POS_W'(KEY_COLS - 1)) ? '0 : x + POS_W'(1);
    endfunction

    // First match in row-major order wins; no match gives row 0, column 0.
    function automatic t_pos f_locate(t_key_sq key, logic [CODE_W-1:0] code);
        t_pos p;
        p = '0;
        for (int i = KEY_ROWS - 1; i >= 0; i--) begin
            for (int j = KEY_COLS - 1; j >= 0; j--) begin
                if (key[i][j*CODE_W +: CODE_W] == code) begin
                    p.row = POS_W'(i);
                    p.col = POS_W'(j);
                end
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/pf_pair_cipher.sv
// ----------------------------------------------------------------------------
// Playfair pair cipher
// Encrypts one letter pair against the key square (combinational).
// ----------------------------------------------------------------------------
module pf_pair_cipher import pf_pkg::*; (
    input  t_key_sq            i_key,
    input  logic [CODE_W-1:0]  i_a,
    input  logic [CODE_W-1:0]  i_b,
    output logic [CODE_W-1:0]  o_ea,
    output logic [CODE_W-1:0]  o_eb
);

    t_pos pos_a;
    t_pos pos_b;

    assign pos_a = f_locate(i_key, i_a);
    assign pos_b = f_locate(i_key, i_b);

    always_comb begin
        if (pos_a.row == pos_b.row) begin
            o_ea = f_cell(i_key, pos_a.row, f_wrap_inc(pos_a.col));
            o_eb = f_cell(i_key, pos_b.row, f_wrap_inc(pos_b.col));
        end else if (pos_a.col == pos_b.col) begin
            o_ea = f_cell(i_key, f_wrap_inc(pos_a.row), pos_a.col);
            o_eb = f_cell(i_key, f_wrap_inc(pos_b.row), pos_b.col);
        end else begin
            // rectangle corners swap
            o_ea = f_cell(i_key, pos_a.row, pos_b.col);
            o_eb = f_cell(i_key, pos_b.row, pos_a.col);
        end
    end

endmodule

>>> rtl/pf_result_queue.sv
// ----------------------------------------------------------------------------
// Playfair result queue
// Four-entry shifting queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module pf_result_queue import pf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_entry0,
    input  t_result    i_entry1,
    output logic       o_room_two,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_entry
);

    localparam int DEPTH = 4;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;
    logic [2:0] base;

    assign o_valid    = (r_count != 3'd0);
    assign o_entry    = r_q[0];
    assign o_room_two = (r_count <= 3'(DEPTH - 2));
    assign pop        = o_valid && i_ready;
    assign base       = r_count - {2'b00, pop};

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (pop && k < DEPTH - 1) begin
                n_q[k] = r_q[k+1];
            end else begin
                n_q[k] = r_q[k];
            end
        end
        // producer only pushes while at most two entries are held
        if (i_push_cnt != 2'd0) begin
            n_q[base[1:0]] = i_entry0;
        end
        if (i_push_cnt == 2'd2) begin
            n_q[base[1:0] + 2'd1] = i_entry1;
        end
        n_count = base + {1'b0, i_push_cnt};
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/playfair_encrypt_stream.sv
// ----------------------------------------------------------------------------
// Playfair encrypt stream
// Byte-stream Playfair encryption against a programmable 5x5 key square.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one plaintext byte per transfer in s_axis_tdata, s_axis_tlast
//    marks the final byte of a message. Case is folded, J maps to I, and
//    non-letters are dropped.
//  - Master stream: one ciphertext letter per transfer (upper-case ASCII in
//    m_axis_tdata), m_axis_tuser set when a letter is carried, m_axis_tlast on
//    the last result of a message. A message ending with no held letter and
//    no letter in its final byte gives one empty result with tlast set.
//  - Config channel: index 0..4 writes key rows 0..4 (column 0 in bits 4:0).
//    Always ready; write only while the stream is idle. Other indexes ignored.
// Timing: one byte accepted per cycle sustained. A byte lands in the input
// register, and from there the decode / pair cipher logic pushes 0, 1 or 2
// results into a four-entry queue, whose registered head is offered on the
// master stream. The input stage stalls only when the queue cannot take two
// more results; a stalled receiver fills the queue up to that point and then
// holds off s_axis_tready, without losing or reordering anything.
// Reset: the key square returns to its default, the held half pair is
// cleared and the queue is emptied.
// ----------------------------------------------------------------------------
module playfair_encrypt_stream import pf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // plaintext in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] in_byte
    input  logic                 s_axis_tlast,  // end_of_message
    // ciphertext out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [6:0] out_letter, [7] zero fill
    output logic                 m_axis_tuser,  // [0] letter_valid
    output logic                 m_axis_tlast,  // message_done
    // key configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eom;

    // key square and half-pair state
    t_key_sq           r_key;
    logic              r_held;
    logic [CODE_W-1:0] r_held_letter;
    logic              n_held;
    logic [CODE_W-1:0] n_held_letter;

    logic              room_two;
    logic              advance;

    logic [BYTE_W-1:0] byte_uc;
    logic [BYTE_W-1:0] byte_off;
    logic              is_letter;
    logic [CODE_W-1:0] code_raw;
    logic [CODE_W-1:0] code;

    logic [CODE_W-1:0] pair_a;
    logic [CODE_W-1:0] pair_b;
    logic              pair_done;
    logic [1:0]        n_results;
    logic [CODE_W-1:0] enc_a;
    logic [CODE_W-1:0] enc_b;
    t_result           entry0;
    t_result           entry1;
    logic [1:0]        push_cnt;
    t_result           q_out;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && room_two;
    assign s_axis_tready = !r_in_valid || advance;

    // ---- letter decode ----
    always_comb begin
        if (r_byte >= ASCII_LC_A && r_byte <= ASCII_LC_Z) begin
            byte_uc = r_byte - CASE_OFFSET;
        end else begin
            byte_uc = r_byte;
        end
        is_letter = (byte_uc >= ASCII_UC_A) && (byte_uc <= ASCII_UC_Z);
        byte_off  = byte_uc - ASCII_UC_A;
        code_raw  = byte_off[CODE_W-1:0];
        code      = (code_raw == CODE_J) ? CODE_I : code_raw;
    end

    // ---- pairing ----
    always_comb begin
        pair_a        = r_held_letter;
        pair_b        = code;
        pair_done     = r_eom;
        n_results     = 2'd0;
        n_held        = r_held;
        n_held_letter = r_held_letter;
        if (is_letter) begin
            if (r_held) begin
                n_results = 2'd2;
                n_held    = 1'b0;
            end else if (r_eom) begin
                // lone final letter pads with X
                pair_a    = code;
                pair_b    = CODE_X;
                n_results = 2'd2;
            end else begin
                n_held        = 1'b1;
                n_held_letter = code;
            end
        end else if (r_eom) begin
            if (r_held) begin
                pair_b    = CODE_X;
                n_results = 2'd2;
            end else begin
                n_results = 2'd1;  // empty end marker
            end
        end
        if (r_eom) begin
            n_held        = 1'b0;
            n_held_letter = '0;
        end
    end

    pf_pair_cipher u_cipher (
        .i_key (r_key),
        .i_a   (pair_a),
        .i_b   (pair_b),
        .o_ea  (enc_a),
        .o_eb  (enc_b)
    );

    always_comb begin
        if (n_results == 2'd1) begin
            entry0 = '{done: 1'b1, valid: 1'b0, letter: '0};
        end else begin
            entry0 = '{done: 1'b0, valid: 1'b1, letter: LETTER_A + LETTER_W'(enc_a)};
        end
        entry1   = '{done: pair_done, valid: 1'b1, letter: LETTER_A + LETTER_W'(enc_b)};
        push_cnt = advance ? n_results : 2'd0;
    end

    pf_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_entry0   (entry0),
        .i_entry1   (entry1),
        .o_room_two (room_two),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_entry    (q_out)
    );

    assign m_axis_tdata = {1'b0, q_out.letter};
    assign m_axis_tuser = q_out.valid;
    assign m_axis_tlast = q_out.done;

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
            r_eom  <= s_axis_tlast;
        end
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_held        <= 1'b0;
            r_held_letter <= '0;
            r_key         <= KEY_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_held        <= n_held;
                r_held_letter <= n_held_letter;
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < CFG_IDX_W'(KEY_ROWS)) begin
                r_key[i_cfg_index] <= i_cfg_data;
            end
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encrypt stream testbench
// Drives plaintext bytes and key squares into the block and checks every
// ciphertext transfer against a cycle-free prediction of the cipher, with
// random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import pf_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PIPE_SETTLE  = 6;     // input reg + result queue + margin
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 40;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;  // [7:0] in_byte
    logic                 s_axis_tlast  = 1'b0; // end_of_message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // [6:0] out_letter, [7] zero fill
    logic                 m_axis_tuser;        // [0] letter_valid
    logic                 m_axis_tlast;        // message_done
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [ROW_W-1:0]     i_cfg_data    = '0;

    playfair_encrypt_stream DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cipher prediction: own copy of the key square and the half pair
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  key_model [KEY_ROWS];
    logic [ROW_W-1:0]  pending_sq [KEY_ROWS];  // next square to program
    logic              held_valid;
    logic [CODE_W-1:0] held_code;
    t_result           expected_cipher [$];
    t_result           cipher_head;

    // run statistics
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int bytes_sent    = 0;
    int msgs_sent     = 0;
    int results_seen  = 0;
    int squares_used  = 0;
    int input_stalls  = 0;

    // idle control, percent of cycles each side sits out
    int src_idle_pct  = 36;
    int sink_idle_pct = 36;
    int sink_hold     = 0;

    function automatic void reset_cipher_model();
        key_model[0] = 25'd4294688;
        key_model[1] = 25'd10755269;
        key_model[2] = 25'd16201099;
        key_model[3] = 25'd21613104;
        key_model[4] = 25'd27025109;
        held_valid   = 1'b0;
        held_code    = '0;
    endfunction

    function automatic logic [CODE_W-1:0] sq_cell(input int r, input int c);
        return key_model[r % KEY_ROWS][CODE_W*(c % KEY_COLS) +: CODE_W];
    endfunction

    // row-major scan, first hit wins; a letter not in the square sits at 0,0
    function automatic void find_code(input logic [CODE_W-1:0] code,
                                      output int r, output int c);
        bit found;
        found = 1'b0;
        r = 0;
        c = 0;
        for (int i = 0; i < KEY_ROWS; i++) begin
            for (int j = 0; j < KEY_COLS; j++) begin
                if (!found && sq_cell(i, j) == code) begin
                    found = 1'b1;
                    r = i;
                    c = j;
                end
            end
        end
    endfunction

    function automatic void push_result(input logic [CODE_W-1:0] code,
                                        input logic valid, input logic done);
        t_result e;
        e.letter = valid ? LETTER_A + LETTER_W'(code) : '0;
        e.valid  = valid;
        e.done   = done;
        expected_cipher.push_back(e);
    endfunction

    function automatic void push_pair(input logic [CODE_W-1:0] a,
                                      input logic [CODE_W-1:0] b, input logic done);
        int ra, ca, rb, cb;
        logic [CODE_W-1:0] ea, eb;
        find_code(a, ra, ca);
        find_code(b, rb, cb);
        // row test first: identical letters land here too
        if (ra == rb) begin
            ea = sq_cell(ra, ca + 1);
            eb = sq_cell(rb, cb + 1);
        end else if (ca == cb) begin
            ea = sq_cell(ra + 1, ca);
            eb = sq_cell(rb + 1, cb);
        end else begin
            ea = sq_cell(ra, cb);
            eb = sq_cell(rb, ca);
        end
        push_result(ea, 1'b1, 1'b0);
        push_result(eb, 1'b1, done);
    endfunction

    function automatic void predict_cipher(input logic [7:0] b, input logic last);
        logic [7:0]        ch;
        logic              is_letter;
        logic [CODE_W-1:0] code;
        ch = b;
        if (ch >= ASCII_LC_A && ch <= ASCII_LC_Z)
            ch = ch - CASE_OFFSET;
        is_letter = (ch >= ASCII_UC_A && ch <= ASCII_UC_Z);
        code = is_letter ? CODE_W'(ch - ASCII_UC_A) : '0;
        if (code == CODE_J)
            code = CODE_I;
        if (is_letter) begin
            if (held_valid) begin
                push_pair(held_code, code, last);
                held_valid = 1'b0;
            end else if (last) begin
                push_pair(code, CODE_X, 1'b1);
            end else begin
                held_valid = 1'b1;
                held_code  = code;
            end
        end else if (last) begin
            if (held_valid)
                push_pair(held_code, CODE_X, 1'b1);
            else
                push_result('0, 1'b0, 1'b1);   // empty end-of-message marker
        end
        if (last) begin
            held_valid = 1'b0;
            held_code  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_PRINTS)
            $display("ERROR cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk)
        cycle_cnt++;

    // every master transfer is matched against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cipher.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer data %02h user %b last %b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                cipher_head = expected_cipher.pop_front();
                if (m_axis_tdata !== {1'b0, cipher_head.letter} ||
                    m_axis_tuser !== cipher_head.valid ||
                    m_axis_tlast !== cipher_head.done)
                    report_mismatch($sformatf(
                        "result %0d: got data %02h user %b last %b, want %02h %b %b",
                        results_seen, m_axis_tdata, m_axis_tuser, m_axis_tlast,
                        {1'b0, cipher_head.letter}, cipher_head.valid, cipher_head.done));
                results_seen++;
            end
        end
    end

    // receiver: random idling, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results pending",
                 LIMIT_CYCLES, expected_cipher.size());
        $display("playfair_encrypt_stream: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One plaintext transfer; random gaps before it carry junk on tdata.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        predict_cipher(b, last);
        bytes_sent++;
        if (last)
            msgs_sent++;
    endtask

    task automatic send_string(input string s, input bit end_msg);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_msg && (i == s.len() - 1));
    endtask

    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [ROW_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < KEY_ROWS)
            key_model[idx] = val;
    endtask

    // Program pending_sq; the spare indexes above the rows must be ignored.
    task automatic load_square(input bit with_spare);
        for (int r = 0; r < KEY_ROWS; r++)
            write_key_reg(CFG_IDX_W'(r), pending_sq[r]);
        if (with_spare) begin
            for (int k = KEY_ROWS; k < (1 << CFG_IDX_W); k++)
                write_key_reg(CFG_IDX_W'(k), ROW_W'($urandom));
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        squares_used++;
    endtask

    // Stream quiet: input dropped, all results back, pipeline flushed.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_cipher.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // A shuffled alphabet less one letter, J most of the time.
    task automatic make_shuffled_square();
        logic [CODE_W-1:0] pool [26];
        logic [CODE_W-1:0] t;
        int n, k, skip;
        skip = $urandom_range(0, 1) ? int'(CODE_J) : int'($urandom_range(0, 25));
        n = 0;
        for (int c = 0; c < 26; c++) begin
            if (c != skip) begin
                pool[n] = CODE_W'(c);
                n++;
            end
        end
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = pool[i];
            pool[i] = pool[k];
            pool[k] = t;
        end
        for (int r = 0; r < KEY_ROWS; r++)
            for (int c = 0; c < KEY_COLS; c++)
                pending_sq[r][CODE_W*c +: CODE_W] = pool[KEY_COLS*r + c];
    endtask

    function automatic logic [7:0] random_plain_byte(input int letter_pct);
        logic [7:0] ch;
        if ($urandom_range(0, 99) < letter_pct) begin
            ch = ASCII_UC_A + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1))
                ch = ch + CASE_OFFSET;
        end else begin
            ch = 8'($urandom_range(0, 255));
        end
        return ch;
    endfunction

    // Mostly letter-heavy messages; one in ten is mostly noise.
    task automatic send_random_message();
        int len, pct;
        len = $urandom_range(1, 14);
        pct = ($urandom_range(0, 9) == 0) ? 15 : 85;
        for (int i = 0; i < len; i++)
            send_byte(random_plain_byte(pct), i == len - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Default square: folding, J to I, dropped bytes, every pair geometry
    // and every way a message can end.
    task automatic test_reset_square();
        send_string("aBAFAGJi", 1'b0);   // row, column, rectangle, identical
        send_byte("Z", 1'b1);            // lone final letter padded with X
        send_byte("q", 1'b0);
        send_byte(8'hFF, 1'b1);          // held letter, final byte no letter
        send_byte(8'h00, 1'b1);          // nothing held: empty marker
        send_string("@[`{", 1'b0);       // neighbors of both letter ranges
        send_byte(8'h80, 1'b0);
        send_byte("z", 1'b0);
        send_byte("j", 1'b1);            // held letter completed by final byte
        wait_idle();
    endtask

    // All-zero square (every cell A) and all-ones square (no letter found,
    // cells above Z emitted); spare indexes written and ignored.
    task automatic test_square_extremes();
        for (int r = 0; r < KEY_ROWS; r++)
            pending_sq[r] = '0;
        load_square(1'b0);
        send_string("ABc", 1'b1);
        wait_idle();
        for (int r = 0; r < KEY_ROWS; r++)
            pending_sq[r] = '1;
        load_square(1'b1);
        send_string("Hi!", 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int budget;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 3 == 1) begin
                for (int r = 0; r < KEY_ROWS; r++)
                    pending_sq[r] = ROW_W'($urandom);   // duplicates, codes above Z
            end else begin
                make_shuffled_square();
            end
            load_square(phase == 4);
            budget = bytes_sent + 48;
            while (bytes_sent < budget)
                send_random_message();
            wait_idle();
        end
    endtask

    // No idling on either side for a stretch.
    task automatic test_full_rate();
        int budget;
        make_shuffled_square();
        load_square(1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        budget = bytes_sent + 60;
        while (bytes_sent < budget)
            send_random_message();
        wait_idle();
        src_idle_pct  = 36;
        sink_idle_pct = 36;
    endtask

    // Receiver holds off while letters keep coming: the result queue fills
    // and the input side must stall without dropping anything.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_hold    = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_byte(random_plain_byte(100), (i % 9 == 8) || (i == 39));
        src_idle_pct = 36;
        wait_idle();
    endtask

    initial begin
        reset_cipher_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_square();
        test_square_extremes();
        test_random_traffic();
        test_full_rate();
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_cipher.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_cipher.size()));

        $display("covered %0d plaintext bytes in %0d messages under %0d key squares",
                 bytes_sent, msgs_sent, squares_used);
        $display("checked %0d ciphertext transfers, %0d input stall cycles, %0d errors",
                 results_seen, input_stalls, err_cnt);
        if (err_cnt == 0) begin
            $display("playfair_encrypt_stream: match");
        end else begin
            $display("playfair_encrypt_stream: mismatch");
        end
        $finish;
    end

endmodule
